// ===== rtl/versioned_queue_unit_assert.svh =====
// Assertion macros for the versioned queue unit.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef VERSIONED_QUEUE_UNIT_ASSERT_SVH
`define VERSIONED_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define VQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VQ_ASSERT_IMP(label, ante, cons, msg)
`define VQ_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/vq_pkg.sv =====
// Shared constants, codes and types of the versioned queue unit.
// Has no dependencies; every module of the unit and the testbench import it.
package vq_pkg;

    localparam int VERSIONS = 64;
    localparam int VALUE_BITS = 32;
    localparam int STORE = 64;
    localparam int IDX_BITS = 6;
    localparam int FIELD_BITS = 32;
    localparam int NODE_BITS = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

    typedef logic [IDX_BITS-1:0] idx_t;

    localparam idx_t NEWEST_MAX = IDX_BITS'(VERSIONS - 1);

    typedef enum logic [1:0] {
        KIND_ENQ,
        KIND_DEQ,
        KIND_READ,
        KIND_NONE
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_EMPTY,
        STAT_FULL,
        STAT_NO_VERSION
    } status_t;

    typedef struct packed {
        idx_t head;
        idx_t tail;
        logic empty;
    } ver_entry_t;

    typedef struct packed {
        logic       en;
        idx_t       addr;
        ver_entry_t entry;
    } ver_wr_t;

    typedef struct packed {
        logic                 en;
        idx_t                 addr;
        logic [NODE_BITS-1:0] data;
    } node_wr_t;

endpackage

// ===== rtl/vq_version_store.sv =====
// Version store: head, tail and empty mark of every version in one synchronous memory.
// Depends on vq_pkg. Version zero always reads as the empty queue.
module vq_version_store
    import vq_pkg::*;
(
    input  logic       clk,
    input  idx_t       rd_addr,
    output ver_entry_t rd_entry,
    input  ver_wr_t    wr
);

    ver_entry_t mem [STORE];
    ver_entry_t rd_data_reg;
    logic       rd_zero_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        rd_data_reg <= mem[rd_addr];
        rd_zero_reg <= (rd_addr == '0);
    end

    always_comb
    begin
        rd_entry = rd_data_reg;
        if (rd_zero_reg)
        begin
            rd_entry.empty = 1'b1;
        end
    end

endmodule

// ===== rtl/vq_node_store.sv =====
// Node store: element values of all appended nodes in one synchronous memory.
// Depends on vq_pkg. Read data is widened to the item field width.
module vq_node_store
    import vq_pkg::*;
(
    input  logic                  clk,
    input  idx_t                  rd_addr,
    output logic [FIELD_BITS-1:0] rd_value,
    input  node_wr_t              wr
);

    logic [NODE_BITS-1:0] mem [STORE];
    logic [NODE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_value = FIELD_BITS'(rd_data_reg);

endmodule

// ===== rtl/versioned_queue_unit.sv =====
// Top level of the versioned queue unit: command handshake, sequencer and result register.
// Depends on vq_pkg, vq_version_store, vq_node_store and the assertion macro header.
//
// A command is taken when start is high and busy is low. An enqueue, a dequeue, an unused
// kind, or a read that yields a single result reads the version entry as it is taken, then
// updates the stores and registers the result. A read of a version holding elements then
// walks them in order; the node store has one read port and the walk fetches one node per
// cycle. Each result is shown for exactly one cycle with result_strobe high and cannot be
// held off; a read streams its elements on consecutive cycles with last high on the final
// one. No clearing pass is needed after reset.
`include "versioned_queue_unit_assert.svh"

module versioned_queue_unit
    import vq_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   kind,
    input  logic signed [FIELD_BITS-1:0] value,
    input  logic [IDX_BITS-1:0]          version,
    output logic                         result_strobe,
    output logic [1:0]                   status,
    output logic                         has_value,
    output logic signed [FIELD_BITS-1:0] item_value,
    output logic [IDX_BITS-1:0]          newest_version,
    output logic                         last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } state_t;

    state_t                state_reg, state_next;
    idx_t                  newest_reg, newest_next;
    idx_t                  node_count_reg, node_count_next;
    kind_t                 kind_reg, kind_next;
    logic [FIELD_BITS-1:0] value_reg, value_next;
    logic                  too_new_reg, too_new_next;
    idx_t                  p_reg, p_next;
    idx_t                  t_reg, t_next;
    idx_t                  cnt_reg, cnt_next;
    logic                  strobe_reg, strobe_next;
    status_t               status_reg, status_next;
    logic                  has_reg, has_next;
    logic [FIELD_BITS-1:0] item_reg, item_next;
    logic                  last_reg, last_next;

    logic                  accept;
    logic                  full;
    logic                  end_walk;
    idx_t                  nv;
    idx_t                  ver_rd_addr;
    ver_entry_t            cur;
    ver_wr_t               ver_wr;
    idx_t                  node_rd_addr;
    logic [FIELD_BITS-1:0] node_rd_value;
    node_wr_t              node_wr;

    vq_version_store u_version_store (
        .clk      (clk),
        .rd_addr  (ver_rd_addr),
        .rd_entry (cur),
        .wr       (ver_wr)
    );

    vq_node_store u_node_store (
        .clk      (clk),
        .rd_addr  (node_rd_addr),
        .rd_value (node_rd_value),
        .wr       (node_wr)
    );

    assign accept      = start && (state_reg == ST_IDLE);
    assign full        = (newest_reg >= NEWEST_MAX);
    assign nv          = newest_reg + IDX_BITS'(1);
    assign end_walk    = (p_reg == t_reg) || (cnt_reg == '1);
    assign ver_rd_addr = (kind_t'(kind) == KIND_READ) ? version : newest_reg;

    always_comb
    begin
        state_next      = state_reg;
        newest_next     = newest_reg;
        node_count_next = node_count_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        too_new_next    = too_new_reg;
        p_next          = p_reg;
        t_next          = t_reg;
        cnt_next        = cnt_reg;
        strobe_next     = 1'b0;
        status_next     = STAT_OK;
        has_next        = 1'b0;
        item_next       = '0;
        last_next       = 1'b1;
        ver_wr          = '0;
        node_wr         = '0;
        node_rd_addr    = p_reg + IDX_BITS'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next    = kind_t'(kind);
                    value_next   = value;
                    too_new_next = (version > newest_reg);
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
                unique case (kind_reg)
                    KIND_ENQ:
                    begin
                        if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            node_wr.en          = 1'b1;
                            node_wr.addr        = node_count_reg;
                            node_wr.data        = value_reg[NODE_BITS-1:0];
                            ver_wr.en           = 1'b1;
                            ver_wr.addr         = nv;
                            ver_wr.entry.head   = cur.empty ? node_count_reg : cur.head;
                            ver_wr.entry.tail   = node_count_reg;
                            ver_wr.entry.empty  = 1'b0;
                            node_count_next     = node_count_reg + IDX_BITS'(1);
                            newest_next         = nv;
                        end
                    end
                    KIND_DEQ:
                    begin
                        if (cur.empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            ver_wr.en         = 1'b1;
                            ver_wr.addr       = nv;
                            ver_wr.entry.tail = cur.tail;
                            if (cur.head == cur.tail)
                            begin
                                ver_wr.entry.head  = cur.head;
                                ver_wr.entry.empty = 1'b1;
                            end
                            else
                            begin
                                ver_wr.entry.head  = cur.head + IDX_BITS'(1);
                                ver_wr.entry.empty = 1'b0;
                            end
                            newest_next = nv;
                        end
                    end
                    KIND_READ:
                    begin
                        if (too_new_reg)
                        begin
                            status_next = STAT_NO_VERSION;
                        end
                        else if (!cur.empty)
                        begin
                            strobe_next  = 1'b0;
                            node_rd_addr = cur.head;
                            p_next       = cur.head;
                            t_next       = cur.tail;
                            cnt_next     = '0;
                            state_next   = ST_WALK;
                        end
                    end
                    KIND_NONE:
                    begin
                        status_next = STAT_OK;
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            ST_WALK:
            begin
                strobe_next = 1'b1;
                has_next    = 1'b1;
                item_next   = node_rd_value;
                last_next   = end_walk;
                if (end_walk)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    p_next   = p_reg + IDX_BITS'(1);
                    cnt_next = cnt_reg + IDX_BITS'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            newest_reg     <= '0;
            node_count_reg <= '0;
            kind_reg       <= KIND_NONE;
            value_reg      <= '0;
            too_new_reg    <= 1'b0;
            p_reg          <= '0;
            t_reg          <= '0;
            cnt_reg        <= '0;
            strobe_reg     <= 1'b0;
            status_reg     <= STAT_OK;
            has_reg        <= 1'b0;
            item_reg       <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            newest_reg     <= newest_next;
            node_count_reg <= node_count_next;
            kind_reg       <= kind_next;
            value_reg      <= value_next;
            too_new_reg    <= too_new_next;
            p_reg          <= p_next;
            t_reg          <= t_next;
            cnt_reg        <= cnt_next;
            strobe_reg     <= strobe_next;
            status_reg     <= status_next;
            has_reg        <= has_next;
            item_reg       <= item_next;
            last_reg       <= last_next;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign result_strobe  = strobe_reg;
    assign status         = status_reg;
    assign has_value      = has_reg;
    assign item_value     = item_reg;
    assign newest_version = newest_reg;
    assign last           = last_reg;

    `VQ_ASSERT_NXT(a_walk_continues, result_strobe && !last, result_strobe, "walk stopped early")
    `VQ_ASSERT_IMP(a_error_single, result_strobe && (status != STAT_OK), last && !has_value, "bad error item")
    `VQ_ASSERT_IMP(a_idle_after_last, result_strobe && last, !busy, "busy after final item")
    `VQ_ASSERT_IMP(a_no_value_zero, result_strobe && !has_value, item_value == '0, "stray item value")
    `VQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "command taken but unit not busy")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for versioned_queue_unit: directed and random enqueue, dequeue and read items,
// with every result checked against a behavioral model of the persistent queue.
// Depends on vq_pkg and the RTL of the unit.
module tb_top;
    import vq_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        status_t                      status;
        logic                         has_value;
        logic signed [FIELD_BITS-1:0] item_value;
        idx_t                         newest;
        logic                         last;
    } queue_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   kind;
    logic signed [FIELD_BITS-1:0] value;
    logic [IDX_BITS-1:0]          version;
    logic                         result_strobe;
    logic [1:0]                   status;
    logic                         has_value;
    logic signed [FIELD_BITS-1:0] item_value;
    logic [IDX_BITS-1:0]          newest_version;
    logic                         last;

    idx_t                         q_newest;
    logic [IDX_BITS:0]            q_node_count;
    logic signed [FIELD_BITS-1:0] node_vals [STORE];
    idx_t                         ver_head [STORE];
    idx_t                         ver_tail [STORE];
    logic                         ver_empty [STORE];

    queue_result_t results_due[$];
    queue_result_t want;
    int            mismatches;
    int            stall_cycles;

    versioned_queue_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .value          (value),
        .version        (version),
        .result_strobe  (result_strobe),
        .status         (status),
        .has_value      (has_value),
        .item_value     (item_value),
        .newest_version (newest_version),
        .last           (last)
    );

    always #6 clk = ~clk;

    function automatic void expect_result(status_t st, logic hv,
                                          logic signed [FIELD_BITS-1:0] v, logic lst);
        queue_result_t r;
        r.status = st;
        r.has_value = hv;
        r.item_value = v;
        r.newest = q_newest;
        r.last = lst;
        results_due.insert(results_due.size(), r);
    endfunction

    function automatic void advance_queue_model(kind_t op, logic signed [FIELD_BITS-1:0] val,
                                                idx_t ver);
        idx_t cur;
        idx_t nv;
        idx_t node;
        idx_t p;
        idx_t t;
        logic full;
        logic done;
        int   k;
        cur = q_newest;
        nv = cur + 1'b1;
        full = (q_newest >= NEWEST_MAX);
        case (op)
            KIND_ENQ:
            begin
                if (full)
                begin
                    expect_result(STAT_FULL, 1'b0, '0, 1'b1);
                end
                else
                begin
                    node = q_node_count[IDX_BITS-1:0];
                    node_vals[node] = val;
                    ver_head[nv] = ver_empty[cur] ? node : ver_head[cur];
                    ver_tail[nv] = node;
                    ver_empty[nv] = 1'b0;
                    q_node_count = q_node_count + 1'b1;
                    q_newest = nv;
                    expect_result(STAT_OK, 1'b0, '0, 1'b1);
                end
            end
            KIND_DEQ:
            begin
                if (ver_empty[cur])
                begin
                    expect_result(STAT_EMPTY, 1'b0, '0, 1'b1);
                end
                else if (full)
                begin
                    expect_result(STAT_FULL, 1'b0, '0, 1'b1);
                end
                else
                begin
                    ver_tail[nv] = ver_tail[cur];
                    ver_head[nv] = (ver_head[cur] == ver_tail[cur]) ? ver_head[cur]
                                                                     : ver_head[cur] + 1'b1;
                    ver_empty[nv] = (ver_head[cur] == ver_tail[cur]);
                    q_newest = nv;
                    expect_result(STAT_OK, 1'b0, '0, 1'b1);
                end
            end
            KIND_READ:
            begin
                if (ver > q_newest)
                begin
                    expect_result(STAT_NO_VERSION, 1'b0, '0, 1'b1);
                end
                else if (ver_empty[ver])
                begin
                    expect_result(STAT_OK, 1'b0, '0, 1'b1);
                end
                else
                begin
                    p = ver_head[ver];
                    t = ver_tail[ver];
                    k = 0;
                    done = 1'b0;
                    while (!done)
                    begin
                        done = (p == t) || (k == STORE - 1);
                        expect_result(STAT_OK, 1'b1, node_vals[p], done);
                        k++;
                        p = p + 1'b1;
                    end
                end
            end
            default:
            begin
                expect_result(STAT_OK, 1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic signed [FIELD_BITS-1:0] random_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic idx_t random_version();
        return idx_t'($urandom);
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic send_item(kind_t op, logic signed [FIELD_BITS-1:0] val, idx_t ver);
        @(negedge clk);
        kind = op;
        value = val;
        version = ver;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        advance_queue_model(op, val, ver);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles == 0)
            return;
        @(negedge clk);
        start = 1'b0;
        kind = 2'($urandom);
        value = $urandom;
        version = idx_t'($urandom);
        repeat (cycles - 1)
        begin
            @(negedge clk);
            kind = 2'($urandom);
            value = $urandom;
            version = idx_t'($urandom);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_queue();
        send_item(KIND_DEQ, $urandom, random_version());
        pause_sender(random_gap());
        send_item(KIND_READ, $urandom, 6'd0);
        send_item(KIND_READ, $urandom, 6'd1);
        pause_sender(random_gap());
        send_item(KIND_READ, $urandom, 6'd63);
        send_item(KIND_NONE, -1, 6'd63);
        wait_drained();
    endtask

    task automatic test_extreme_values();
        send_item(KIND_ENQ, 32'sh8000_0000, 6'd0);
        send_item(KIND_ENQ, 32'sh7fff_ffff, 6'd63);
        pause_sender(random_gap());
        send_item(KIND_ENQ, '0, random_version());
        send_item(KIND_ENQ, -1, random_version());
        send_item(KIND_READ, $urandom, q_newest);
        pause_sender(random_gap());
        send_item(KIND_DEQ, $urandom, random_version());
        send_item(KIND_READ, $urandom, q_newest);
        send_item(KIND_READ, $urandom, 6'd2);
        wait_drained();
    endtask

    task automatic test_drain_and_reuse();
        int emptied_at;
        repeat (3)
        begin
            send_item(KIND_DEQ, $urandom, random_version());
            pause_sender(random_gap());
        end
        emptied_at = int'(q_newest);
        send_item(KIND_DEQ, $urandom, random_version());
        send_item(KIND_READ, $urandom, idx_t'(emptied_at));
        send_item(KIND_ENQ, 32'sd1, random_version());
        send_item(KIND_READ, $urandom, q_newest);
        pause_sender(random_gap());
        send_item(KIND_READ, $urandom, 6'd4);
        wait_drained();
    endtask

    task automatic test_random_mix(int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                send_item(KIND_ENQ, random_value(), random_version());
            else if (r < 22)
                send_item(KIND_DEQ, $urandom, random_version());
            else if (r < 85)
                send_item(KIND_READ, $urandom, idx_t'($urandom_range(0, q_newest)));
            else if (r < 94)
                send_item(KIND_READ, $urandom, random_version());
            else
                send_item(KIND_NONE, $urandom, random_version());
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            else
                pause_sender(random_gap());
        end
        wait_drained();
    endtask

    task automatic test_store_full();
        while (q_newest != NEWEST_MAX)
        begin
            send_item(KIND_ENQ, random_value(), random_version());
            pause_sender(random_gap());
        end
        send_item(KIND_ENQ, random_value(), random_version());
        send_item(KIND_DEQ, $urandom, random_version());
        pause_sender(random_gap());
        send_item(KIND_NONE, $urandom, random_version());
        for (int v = 0; v < STORE; v++)
        begin
            send_item(KIND_READ, $urandom, idx_t'(v));
            pause_sender(random_gap());
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (results_due.size() == 0)
            begin
                $error("result with no item pending");
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (has_value !== want.has_value)
                begin
                    $error("has_value: expected %0d, got %0d", want.has_value, has_value);
                    mismatches++;
                end
                if (item_value !== want.item_value)
                begin
                    $error("item_value: expected %0d, got %0d", want.item_value, item_value);
                    mismatches++;
                end
                if (newest_version !== want.newest)
                begin
                    $error("newest_version: expected %0d, got %0d", want.newest,
                           newest_version);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = '0;
        value = '0;
        version = '0;
        mismatches = 0;
        stall_cycles = 0;
        q_newest = '0;
        q_node_count = '0;
        for (int i = 0; i < STORE; i++)
        begin
            node_vals[i] = '0;
            ver_head[i] = '0;
            ver_tail[i] = '0;
            ver_empty[i] = (i == 0);
        end
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_queue();
        test_extreme_values();
        test_drain_and_reuse();
        test_random_mix(190);
        test_store_full();

        repeat (20)
            @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vq_pkg.sv
rtl/vq_version_store.sv
rtl/vq_node_store.sv
rtl/versioned_queue_unit.sv
test/tb_top.sv
